// ----- design/itpt_pkg.sv -----
// Shared types and constants for the image transfer pack tracker.
// Used by itpt_ctrl, itpt_datapath and image_transfer_pack_tracker_core.
// No dependencies.
package itpt_pkg;

    // Item operation codes.
    localparam logic OP_START    = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    // Configuration register indexes.
    localparam logic REG_IMAGE_SIZE = 1'b0;
    localparam logic REG_PACK_SIZE  = 1'b1;

    // Response payload length that the peer must send.
    localparam logic [15:0] RESP_LEN = 16'd4;

    // Pack number that marks a peer failure.
    localparam logic [31:0] PEER_FAIL_MARK = 32'hffff_ffff;

    // The dividend is 33 bits wide, one quotient bit per step.
    localparam int DIV_STEPS = 33;
    localparam int CNT_W     = 6;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_INFO_SENT  = 3'd0,
        STAT_INFO_ERR   = 3'd1,
        STAT_FIRST      = 3'd2,
        STAT_NEXT       = 3'd3,
        STAT_DONE       = 3'd4,
        STAT_FAILED     = 3'd5,
        STAT_BAD_LEN    = 3'd6,
        STAT_NOT_ACTIVE = 3'd7
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_DELIVER
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div_step;
        logic div_last;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic out_free;
    } sts_t;

endpackage

// ----- design/itpt_ctrl.sv -----
// Controller state machine of the pack tracker: sequences accept, divide and delivery.
// Depends on itpt_pkg.
module itpt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  itpt_pkg::sts_t sts,
    output itpt_pkg::cmd_t cmd
);
    import itpt_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               last_step;

    assign last_step = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    state_next = sts.need_div ? S_DIVIDE : S_DELIVER;
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = last_step;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    state_next = S_DELIVER;
                end
            end
            S_DELIVER:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/itpt_datapath.sv -----
// Datapath of the pack tracker: configuration, transfer state, serial divider
// and the output register. Depends on itpt_pkg.
module itpt_datapath
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic           cfg_addr,
    input  logic [31:0]    cfg_data,
    input  logic           operation,
    input  logic [15:0]    payload_len,
    input  logic [31:0]    pack_number,
    input  logic           out_ready,
    output logic           out_valid,
    output logic [2:0]     status,
    output logic [31:0]    requested_pack,
    output logic [31:0]    total_packs,
    input  itpt_pkg::cmd_t cmd,
    output itpt_pkg::sts_t sts
);
    import itpt_pkg::*;

    logic [31:0] image_size_reg;
    logic [15:0] pack_size_reg;

    logic        active_reg;
    logic        active_next;
    logic [31:0] total_reg;
    logic [31:0] total_next;
    logic [31:0] next_pack_reg;
    logic [31:0] next_pack_next;
    status_t     stat_reg;
    status_t     stat_next;

    logic [15:0] div_reg;
    logic [15:0] div_next;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [32:0] quo_reg;
    logic [32:0] quo_next;
    logic [16:0] trial;
    logic        trial_ge;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [2:0]  out_status_reg;
    logic [31:0] out_req_reg;
    logic [31:0] out_total_reg;

    logic [32:0] sum33;
    logic [32:0] last33;
    logic [32:0] pnum33;

    assign sts.need_div = (operation == OP_START) && (pack_size_reg != 16'd0);
    assign sts.out_free = !out_valid_reg || out_ready;

    // Exact 33-bit terms for the start sum and the completion compare.
    assign sum33  = {1'b0, image_size_reg} + {17'd0, pack_size_reg} - 33'd1;
    assign last33 = {1'b0, total_reg} + 33'd1;
    assign pnum33 = {1'b0, pack_number};

    // One restoring division step.
    assign trial    = {rem_reg, quo_reg[32]};
    assign trial_ge = (trial >= {1'b0, div_reg});

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= '0;
            pack_size_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_IMAGE_SIZE: image_size_reg <= cfg_data;
                REG_PACK_SIZE:  pack_size_reg  <= cfg_data[15:0];
                default:        image_size_reg <= image_size_reg;
            endcase
        end
    end

    // Transfer state, item evaluation and divider updates.
    always_comb
    begin
        active_next    = active_reg;
        total_next     = total_reg;
        next_pack_next = next_pack_reg;
        stat_next      = stat_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        if (cmd.accept)
        begin
            if (operation == OP_START)
            begin
                if (pack_size_reg == 16'd0)
                begin
                    active_next = 1'b0;
                    total_next  = '0;
                    stat_next   = STAT_INFO_ERR;
                end
                else
                begin
                    div_next  = pack_size_reg;
                    rem_next  = '0;
                    quo_next  = sum33;
                    stat_next = STAT_INFO_SENT;
                end
            end
            else if (payload_len != RESP_LEN)
            begin
                stat_next = STAT_BAD_LEN;
            end
            else if (!active_reg)
            begin
                stat_next = STAT_NOT_ACTIVE;
            end
            else if (pack_number == PEER_FAIL_MARK)
            begin
                active_next = 1'b0;
                stat_next   = STAT_FAILED;
            end
            else if (pnum33 == last33)
            begin
                active_next = 1'b0;
                stat_next   = STAT_DONE;
            end
            else if ((pnum33 > last33) || (pack_number == 32'd0))
            begin
                active_next = 1'b0;
                stat_next   = STAT_FAILED;
            end
            else
            begin
                next_pack_next = pack_number;
                stat_next      = (pack_number == 32'd1) ? STAT_FIRST : STAT_NEXT;
            end
        end
        else if (cmd.div_step)
        begin
            if (trial_ge)
            begin
                rem_next = 16'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[15:0];
            end
            quo_next = {quo_reg[31:0], trial_ge};
            if (cmd.div_last)
            begin
                total_next  = quo_next[31:0];
                active_next = 1'b1;
            end
        end
    end

    // Control state of the transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            total_reg     <= '0;
            next_pack_reg <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            total_reg     <= total_next;
            next_pack_reg <= next_pack_next;
        end
    end

    // Divider and pending status registers.
    always_ff @(posedge clk)
    begin
        stat_reg <= stat_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= stat_reg;
            out_req_reg    <= next_pack_reg;
            out_total_reg  <= total_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign requested_pack = out_req_reg;
    assign total_packs    = out_total_reg;

endmodule

// ----- design/image_transfer_pack_tracker_core.sv -----
// Top level of the image transfer pack tracker.
// Depends on itpt_pkg, itpt_ctrl and itpt_datapath.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+------------------------------------------
//  config   | cfg_write              | cfg_addr, cfg_data
//  input    | in_valid / in_ready    | operation, payload_len, pack_number
//  output   | out_valid / out_ready  | status, requested_pack, total_packs
//
// A response item, or a start item with a zero pack size, goes from accept straight to
// the deliver state, which loads the output register once it is free. A start item with
// a nonzero pack size first passes the divide state, where the serial divider retires one of
// its 33 quotient bits per cycle. One item is in work at a time; the output register lets
// a new item be accepted while an earlier result still waits on out_ready.
// Reset clears the configuration, the transfer state and the output valid.
module image_transfer_pack_tracker_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [15:0] payload_len,
    input  logic [31:0] pack_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] requested_pack,
    output logic [31:0] total_packs
);
    import itpt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencing of each item.
    itpt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // State, divider and output register.
    itpt_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .payload_len    (payload_len),
        .pack_number    (pack_number),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .requested_pack (requested_pack),
        .total_packs    (total_packs),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
